>>> hdl/instruction_pair_fuser_macros.svh
// ----------------------------------------------------------------------------
// instruction_pair_fuser assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_PAIR_FUSER_MACROS_SVH
`define INSTRUCTION_PAIR_FUSER_MACROS_SVH

// same-cycle implication
`define IPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ipf_pkg.sv
// ----------------------------------------------------------------------------
// ipf_pkg
// types, codes and constants shared by the pair fuser modules
// ----------------------------------------------------------------------------
`default_nettype none

package ipf_pkg;

    localparam int OPCODE_BITS   = 12;
    localparam int POSITION_BITS = 16;
    localparam int DEF_BUCKETS   = 64;
    localparam int DEF_WAYS      = 4;

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_INSTR = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_EMIT    = 2'd0;
    localparam logic [1:0] KIND_LOADED  = 2'd1;
    localparam logic [1:0] KIND_REFUSED = 2'd2;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [OPCODE_BITS-1:0] first_op;
        logic [OPCODE_BITS-1:0] second_op;
        logic [OPCODE_BITS-1:0] combined_op;
        logic [OPCODE_BITS-1:0] instruction;
    } ipf_in_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [OPCODE_BITS-1:0]   emitted_op;
        logic [POSITION_BITS-1:0] position;
        logic                     last;
    } ipf_out_t;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] first;
        logic [OPCODE_BITS-1:0] second;
        logic [OPCODE_BITS-1:0] combined;
    } pair_entry_t;

    typedef struct packed {
        logic rd_en;
        logic load_we;
        logic clr_we;
    } tbl_ctrl_t;

    typedef struct packed {
        logic                   hit;
        logic                   full;
        logic [OPCODE_BITS-1:0] combined_op;
    } tbl_lookup_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_EXEC
    } state_t;

endpackage

`default_nettype wire

>>> hdl/ipf_table.sv
// ----------------------------------------------------------------------------
// ipf_table
// bucket memories of the pair table with slot compare and row update
// ----------------------------------------------------------------------------
`default_nettype none

module ipf_table
    import ipf_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS,
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int FW     = $clog2(WAYS + 1)
)
(
    input  wire logic                   clk,
    input  wire tbl_ctrl_t              ctrl,
    input  wire logic [BW-1:0]          rd_addr,
    input  wire logic [BW-1:0]          wr_addr,
    input  wire logic [OPCODE_BITS-1:0] key_first,
    input  wire logic [OPCODE_BITS-1:0] key_second,
    input  wire pair_entry_t            new_entry,
    output tbl_lookup_t                 lookup
);

    pair_entry_t [WAYS-1:0] slot_mem [BUCKETS];
    logic [FW-1:0]          fill_mem [BUCKETS];

    pair_entry_t [WAYS-1:0] slot_rd_reg;
    logic [FW-1:0]          fill_rd_reg;

    pair_entry_t [WAYS-1:0] row_wr;
    logic [FW-1:0]          fill_wr;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            slot_rd_reg <= slot_mem[rd_addr];
            fill_rd_reg <= fill_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_we)
        begin
            slot_mem[wr_addr] <= row_wr;
        end
        if (ctrl.load_we || ctrl.clr_we)
        begin
            fill_mem[wr_addr] <= fill_wr;
        end
    end

    // newest matching slot wins
    always_comb
    begin
        lookup.hit         = 1'b0;
        lookup.full        = (fill_rd_reg >= FW'(WAYS));
        lookup.combined_op = '0;
        for (int k = 0; k < WAYS; k++)
        begin
            if ((FW'(k) < fill_rd_reg) && (slot_rd_reg[k].first == key_first)
                && (slot_rd_reg[k].second == key_second))
            begin
                lookup.hit         = 1'b1;
                lookup.combined_op = slot_rd_reg[k].combined;
            end
        end
    end

    always_comb
    begin
        fill_wr = ctrl.clr_we ? '0 : FW'(fill_rd_reg + 1'b1);
        for (int k = 0; k < WAYS; k++)
        begin
            row_wr[k] = (FW'(k) == fill_rd_reg) ? new_entry : slot_rd_reg[k];
        end
    end

endmodule

`default_nettype wire

>>> hdl/instruction_pair_fuser.sv
// ----------------------------------------------------------------------------
// instruction_pair_fuser
// fuses adjacent opcodes into superinstructions through a hashed pair table
// ----------------------------------------------------------------------------
//  channel   signals                           direction
//  input     in_valid / in_ready / in_item     in, ipf_in_t
//  output    out_valid / out_ready / out_item  out, ipf_out_t
//  config    cfg_we / cfg_wdata                in, fusion enable
//
//  one transfer at a time: the bucket memory read starts when an item is
//  accepted if BUCKETS is a power of two, else after a hash state (reciprocal
//  multiply for the bucket index); the registered read precedes the slot compare
//  after reset a clearing pass over every bucket zeroes the fill counts
//  a result-producing item waits in the lookup state while the output is full
// ----------------------------------------------------------------------------
`default_nettype none

`include "instruction_pair_fuser_macros.svh"

module instruction_pair_fuser
    import ipf_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ipf_in_t  in_item,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ipf_out_t      out_item,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int XW = (OPCODE_BITS > BW) ? OPCODE_BITS : BW;
    localparam int SH = OPCODE_BITS + BW;
    localparam int PW = XW + SH + 1;
    localparam bit HASH_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [SH:0] RECIP = (SH + 1)'((64'd1 << SH) / BUCKETS);
    localparam logic [XW:0] BUCKETS_W = (XW + 1)'(BUCKETS);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

    state_t                   state_reg, state_next;
    logic [BW-1:0]            clr_cnt_reg, clr_cnt_next;
    ipf_in_t                  req_reg, req_next;
    logic [XW-1:0]            x_reg, x_next;
    logic [PW-1:0]            prod_reg, prod_next;
    logic [BW-1:0]            addr_reg, addr_next;
    logic                     held_valid_reg, held_valid_next;
    logic [OPCODE_BITS-1:0]   held_op_reg, held_op_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     fe_reg;
    logic                     out_valid_reg, out_valid_next;
    ipf_out_t                 out_item_reg, out_item_next;

    logic                     accept;
    logic [XW-1:0]            hash_x;
    logic [BW-1:0]            pow2_addr;
    logic [XW-1:0]            quot;
    logic [XW:0]              rem_raw;
    logic [XW:0]              rem_fix;
    logic [BW-1:0]            rd_addr;
    tbl_ctrl_t                tbl_ctrl;
    tbl_lookup_t              lookup;
    pair_entry_t              new_entry;
    logic                     produce;
    logic                     emit;
    logic                     exec_go;
    ipf_out_t                 result;
    logic                     cand_held_valid;
    logic [OPCODE_BITS-1:0]   cand_held_op;

    ipf_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_table (
        .clk        (clk),
        .ctrl       (tbl_ctrl),
        .rd_addr    (rd_addr),
        .wr_addr    ((state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg),
        .key_first  (held_op_reg),
        .key_second (req_reg.instruction),
        .new_entry  (new_entry),
        .lookup     (lookup)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign new_entry.first    = req_reg.first_op;
    assign new_entry.second   = req_reg.second_op;
    assign new_entry.combined = req_reg.combined_op;

    // bucket hash
    always_comb
    begin
        unique case (in_item.req_type)
            REQ_LOAD:  hash_x = XW'(in_item.first_op ^ in_item.second_op);
            REQ_INSTR: hash_x = XW'(held_op_reg ^ in_item.instruction);
            default:   hash_x = '0;
        endcase
        pow2_addr = (BUCKETS == 1) ? '0 : hash_x[BW-1:0];
        prod_next = PW'(hash_x) * PW'(RECIP);
        quot      = XW'(prod_reg >> SH);
        rem_raw   = (XW + 1)'(x_reg) - (XW + 1)'((XW + 1)'(quot) * BUCKETS_W);
        rem_fix   = (rem_raw >= BUCKETS_W) ? (XW + 1)'(rem_raw - BUCKETS_W) : rem_raw;
        rd_addr   = (state_reg == S_HASH) ? BW'(rem_fix) : pow2_addr;
    end

    // lookup result and hold update
    always_comb
    begin
        produce         = 1'b0;
        emit            = 1'b0;
        result          = '0;
        cand_held_valid = held_valid_reg;
        cand_held_op    = held_op_reg;
        unique case (req_reg.req_type)
            REQ_LOAD:
            begin
                produce     = 1'b1;
                result.kind = lookup.full ? KIND_REFUSED : KIND_LOADED;
            end
            REQ_INSTR:
            begin
                cand_held_valid = 1'b1;
                if (held_valid_reg && fe_reg && lookup.hit)
                begin
                    cand_held_op = lookup.combined_op;
                end
                else
                begin
                    cand_held_op = req_reg.instruction;
                    produce      = held_valid_reg;
                    emit         = held_valid_reg;
                end
                result.kind       = KIND_EMIT;
                result.emitted_op = held_op_reg;
                result.position   = pos_reg;
            end
            REQ_FLUSH:
            begin
                cand_held_valid   = 1'b0;
                produce           = held_valid_reg;
                emit              = held_valid_reg;
                result.kind       = KIND_EMIT;
                result.emitted_op = held_op_reg;
                result.position   = pos_reg;
                result.last       = 1'b1;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
        exec_go = (state_reg == S_EXEC) && (!produce || !out_valid_reg || out_ready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_BUCKET)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = HASH_POW2 ? S_EXEC : S_HASH;
                end
            end
            S_HASH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // outputs and register updates
    always_comb
    begin
        tbl_ctrl.rd_en   = (accept && HASH_POW2) || (state_reg == S_HASH);
        tbl_ctrl.load_we = exec_go && (req_reg.req_type == REQ_LOAD) && !lookup.full;
        tbl_ctrl.clr_we  = (state_reg == S_CLEAR);

        clr_cnt_next    = (state_reg == S_CLEAR) ? BW'(clr_cnt_reg + 1'b1) : clr_cnt_reg;
        req_next        = accept ? in_item : req_reg;
        x_next          = accept ? hash_x : x_reg;
        addr_next       = tbl_ctrl.rd_en ? rd_addr : addr_reg;
        held_valid_next = exec_go ? cand_held_valid : held_valid_reg;
        held_op_next    = exec_go ? cand_held_op : held_op_reg;
        pos_next        = (exec_go && emit) ? POSITION_BITS'(pos_reg + 1'b1) : pos_reg;

        if (exec_go && produce)
        begin
            out_valid_next = 1'b1;
            out_item_next  = result;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            out_item_next  = out_item_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            held_valid_reg <= 1'b0;
            held_op_reg    <= '0;
            pos_reg        <= '0;
            fe_reg         <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            held_valid_reg <= held_valid_next;
            held_op_reg    <= held_op_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                fe_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        x_reg        <= x_next;
        prod_reg     <= (accept && !HASH_POW2) ? prod_next : prod_reg;
        addr_reg     <= addr_next;
        out_item_reg <= out_item_next;
    end

    `IPF_ASSERT_NXT(a_accept_starts_lookup, accept,
        state_reg == S_HASH || state_reg == S_EXEC,
        "accepted transfer did not start a lookup")
    `IPF_ASSERT_NXT(a_position_steps, exec_go && emit,
        pos_reg == POSITION_BITS'($past(pos_reg) + 1'b1),
        "position did not advance on emit")
    `IPF_ASSERT_NXT(a_flush_drops_held, exec_go && req_reg.req_type == REQ_FLUSH,
        !held_valid_reg, "held opcode survived a flush")
    `IPF_ASSERT_IMP(a_no_load_into_full, tbl_ctrl.load_we,
        !lookup.full && state_reg == S_EXEC, "load written into a full bucket")

endmodule

`default_nettype wire
